FILE: hdl/asfr_pkg.sv
// Shared types and constants for the axis status frame receiver.
package asfr_pkg;

    localparam int FrameLen   = 41;
    localparam int SumLen     = 39;
    localparam int StoreDepth = FrameLen - 1;
    localparam int IndexW     = $clog2(FrameLen);

    localparam logic [IndexW-1:0] LastIndex  = IndexW'(FrameLen - 1);
    localparam logic [IndexW-1:0] SumEnd     = IndexW'(SumLen);
    localparam logic [15:0]       SumInvert  = 16'hFF00;

    localparam logic StatusOk          = 1'b0;
    localparam logic StatusChecksumErr = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } asfr_in_t;

    typedef struct packed {
        logic [7:0]  controller_address;
        logic [31:0] x_position;
        logic [31:0] y_position;
        logic [31:0] x_encoder;
        logic [31:0] y_encoder;
        logic [31:0] switch_bytes;
        logic [31:0] analog_pair;
        logic [31:0] motor_clock;
        logic [15:0] temp_and_phase;
        logic [31:0] x_last_bytes;
        logic [31:0] y_last_bytes;
        logic        frame_status;
    } asfr_out_t;

    typedef struct packed {
        logic result_fire;
        logic at_last;
    } asfr_cap_stat_t;

endpackage

FILE: hdl/axis_status_frame_receiver.sv
// Top level of the axis status frame receiver.
// Latency: the result appears in the cycle after the last (41st) byte is accepted.
// Throughput: one byte per cycle; only a byte that arrives while the count stands at
// the last byte can stall, and only while the previous result still waits in the
// output register.
// Reset (rst_n low, asynchronous): byte count, running sum and output valid
// clear; the byte shift line and result payload are not reset.
module axis_status_frame_receiver
    import asfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  asfr_in_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output asfr_out_t out_item
);

    logic           accept;
    asfr_cap_stat_t stat;
    asfr_out_t      result;

    // Ordinary bytes never need the output register, so they are always taken.
    // When the count stands at the last byte, the item is held off until the
    // output register is free or is being emptied in this cycle.
    assign in_ready = !stat.at_last || !out_valid || out_ready;
    assign accept   = in_valid && in_ready;

    asfr_capture u_capture (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_item (in_item),
        .stat    (stat),
        .result  (result)
    );

    asfr_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (stat.result_fire),
        .result    (result),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule

FILE: hdl/asfr_capture.sv
// Byte counter, running sum, byte shift line and frame decode.
module asfr_capture
    import asfr_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  asfr_in_t       in_item,
    output asfr_cap_stat_t stat,
    output asfr_out_t      result
);

    logic [IndexW-1:0] byte_index_reg;
    logic [IndexW-1:0] byte_index_next;
    logic [15:0]       running_sum_reg;
    logic [15:0]       running_sum_next;
    logic [7:0]        store_reg [StoreDepth];
    logic [IndexW-1:0] idx;
    logic [15:0]       rx_sum;
    logic [15:0]       want_sum;

    // The newest byte sits at entry 0, so byte k of a full frame sits at
    // entry StoreDepth-1-k when the last byte arrives.
    function automatic logic [7:0] fb(input int k);
        return store_reg[IndexW'(StoreDepth - 1 - k)];
    endfunction

    assign idx = in_item.frame_start ? '0 : byte_index_reg;

    always_comb
    begin
        byte_index_next  = byte_index_reg;
        running_sum_next = running_sum_reg;
        if (accept)
        begin
            byte_index_next = (idx == LastIndex) ? '0 : idx + IndexW'(1);
            if (idx == '0)
            begin
                running_sum_next = {8'd0, in_item.rx_byte};
            end
            else if (idx < SumEnd)
            begin
                running_sum_next = running_sum_reg + {8'd0, in_item.rx_byte};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg  <= '0;
            running_sum_reg <= '0;
        end
        else
        begin
            byte_index_reg  <= byte_index_next;
            running_sum_reg <= running_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            store_reg[0] <= in_item.rx_byte;
            for (int i = 1; i < StoreDepth; i++)
            begin
                store_reg[IndexW'(i)] <= store_reg[IndexW'(i - 1)];
            end
        end
    end

    assign rx_sum   = {in_item.rx_byte, store_reg[IndexW'(StoreDepth - 1 - SumLen)]};
    assign want_sum = running_sum_reg ^ SumInvert;

    assign stat.result_fire = accept && (idx == LastIndex);
    assign stat.at_last     = (byte_index_reg == LastIndex);

    always_comb
    begin
        result.controller_address = fb(0);
        result.x_position     = {fb(4), fb(3), fb(2), fb(1)};
        result.y_position     = {fb(8), fb(7), fb(6), fb(5)};
        result.x_encoder      = {fb(12), fb(11), fb(10), fb(9)};
        result.y_encoder      = {fb(16), fb(15), fb(14), fb(13)};
        result.switch_bytes   = {fb(20), fb(19), fb(18), fb(17)};
        result.analog_pair    = {fb(24), fb(23), fb(22), fb(21)};
        result.motor_clock    = {fb(28), fb(27), fb(26), fb(25)};
        result.temp_and_phase = {fb(30), fb(29)};
        result.x_last_bytes   = {fb(34), fb(33), fb(32), fb(31)};
        result.y_last_bytes   = {fb(38), fb(37), fb(36), fb(35)};
        result.frame_status   = (rx_sum != want_sum) ? StatusChecksumErr : StatusOk;
    end

endmodule

FILE: hdl/asfr_out_reg.sv
// Result register with valid flag on the output channel.
module asfr_out_reg
    import asfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  asfr_out_t result,
    input  logic      out_ready,
    output logic      out_valid,
    output asfr_out_t out_item
);

    logic      out_valid_reg;
    logic      out_valid_next;
    asfr_out_t out_item_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: hdl/asfr_checker.sv
// Port-level checks for the axis status frame receiver, bound to the top level.
module asfr_checker
    import asfr_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input asfr_in_t  in_item,
    input logic      out_valid,
    input logic      out_ready,
    input asfr_out_t out_item
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("output item changed while stalled");

    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid && !out_ready) |-> $past(in_valid && in_ready))
        else $error("result appeared without an accepted byte");

    a_start_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid && !out_ready) |-> !$past(in_item.frame_start))
        else $error("result caused by a frame start byte");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output register");

endmodule

bind axis_status_frame_receiver asfr_checker u_asfr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
